@@ rtl/core/lcadc_pkg.sv @@
// shared constants, register codes and transaction structs for the load cell converter readout
// no dependencies; imported by lcadc_seq, lcadc_arith and the top level
`timescale 1ns / 1ps
`default_nettype none

package lcadc_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int BIT_CNT_W   = $clog2(SAMPLE_BITS + 1);

  localparam int GAIN_W      = 2;
  localparam int CNT_W       = 8;
  localparam int TMO_W       = 16;
  localparam int SUM_W       = 32;
  localparam int AVG_W       = 24;
  localparam int COR_W       = 32;
  localparam int SCALE_W     = 32;
  localparam int UNITS_W     = 48;
  localparam int PROD_W      = COR_W + SCALE_W;
  localparam int Q_FRAC      = 16;
  localparam int DIV_CNT_W   = $clog2(SUM_W);

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN,
    REG_AVG_CNT,
    REG_OFFSET,
    REG_SCALE,
    REG_TIMEOUT,
    REG_PDOWN
  } cfg_reg_t;

  // per-tick outcome of the sequencer
  typedef struct packed {
    logic                    pd_sck;
    logic                    busy;
    logic                    present;
    logic                    timed_out;
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        count;
  } tick_t;

  // finished measurement from the arithmetic unit
  typedef struct packed {
    logic signed [AVG_W-1:0]   average;
    logic signed [COR_W-1:0]   corrected;
    logic signed [UNITS_W-1:0] units;
  } meas_t;

endpackage

`default_nettype wire

@@ rtl/core/load_cell_adc_reader_unit.sv @@
// load cell converter readout, one input transaction per serial clock tick
// a tick with no finished measurement is registered to the output in the cycle after
// acceptance; a tick that completes a measurement waits for the arithmetic unit: the
// 32-step divider, then sign, offset subtract and two multiply passes
// throughput: one tick per cycle while out_ready is high and the arithmetic unit is idle
// reset: config registers to defaults, sequencer and arithmetic unit idle
`timescale 1ns / 1ps
`default_nettype none

module load_cell_adc_reader_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_start_req,
  input  logic                                  in_dout,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_pd_sck,
  output logic                                  out_done_res,
  output logic signed [lcadc_pkg::AVG_W-1:0]    out_average,
  output logic signed [lcadc_pkg::COR_W-1:0]    out_corrected,
  output logic signed [lcadc_pkg::UNITS_W-1:0]  out_units,
  output logic                                  out_timed_out,
  output logic                                  out_busy_res,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [lcadc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lcadc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import lcadc_pkg::*;

  logic [GAIN_W-1:0]         gain_r;
  logic [CNT_W-1:0]          avg_cnt_r;
  logic signed [COR_W-1:0]   offset_r;
  logic signed [SCALE_W-1:0] scale_r;
  logic [TMO_W-1:0]          timeout_r;
  logic                      pdown_r;

  logic                      out_valid_r;
  logic                      calc_r;
  logic                      pd_r, done_res_r, tmo_res_r, busy_res_r;
  logic signed [AVG_W-1:0]   average_r;
  logic signed [COR_W-1:0]   corrected_r;
  logic signed [UNITS_W-1:0] units_r;
  logic                      meta_pd_r, meta_busy_r, meta_tmo_r;

  tick_t                     tick;
  meas_t                     meas;
  logic                      tick_go;
  logic                      arith_done;

  assign cfg_ready = 1'b1;
  assign in_ready  = !calc_r && (!out_valid_r || out_ready);
  assign tick_go   = in_valid && in_ready;

  lcadc_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .tick_go       (tick_go),
    .start_req     (in_start_req),
    .dout          (in_dout),
    .gain_pulses   (gain_r),
    .average_count (avg_cnt_r),
    .timeout_ticks (timeout_r),
    .power_down    (pdown_r),
    .tick_o        (tick)
  );

  lcadc_arith u_arith (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (tick_go && tick.present),
    .sum_i    (tick.sum),
    .count_i  (tick.count),
    .offset_i (offset_r),
    .scale_i  (scale_r),
    .done_o   (arith_done),
    .res_o    (meas)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= GAIN_W'(1);
      avg_cnt_r   <= CNT_W'(1);
      offset_r    <= '0;
      scale_r     <= SCALE_W'(65536);
      timeout_r   <= TMO_W'(20000);
      pdown_r     <= 1'b0;
      out_valid_r <= 1'b0;
      calc_r      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_GAIN:    gain_r    <= cfg_data[GAIN_W-1:0];
          REG_AVG_CNT: avg_cnt_r <= cfg_data[CNT_W-1:0];
          REG_OFFSET:  offset_r  <= $signed(cfg_data[COR_W-1:0]);
          REG_SCALE:   scale_r   <= $signed(cfg_data[SCALE_W-1:0]);
          REG_TIMEOUT: timeout_r <= cfg_data[TMO_W-1:0];
          REG_PDOWN:   pdown_r   <= cfg_data[0];
          default: ;
        endcase
      end
      if (arith_done) begin
        out_valid_r <= 1'b1;
        calc_r      <= 1'b0;
      end else if (tick_go) begin
        // a finishing tick waits for the arithmetic unit
        out_valid_r <= !tick.present;
        calc_r      <= tick.present;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (arith_done) begin
      pd_r        <= meta_pd_r;
      busy_res_r  <= meta_busy_r;
      tmo_res_r   <= meta_tmo_r;
      done_res_r  <= 1'b1;
      average_r   <= meas.average;
      corrected_r <= meas.corrected;
      units_r     <= meas.units;
    end else if (tick_go) begin
      pd_r        <= tick.pd_sck;
      busy_res_r  <= tick.busy;
      tmo_res_r   <= 1'b0;
      done_res_r  <= 1'b0;
      average_r   <= '0;
      corrected_r <= '0;
      units_r     <= '0;
      meta_pd_r   <= tick.pd_sck;
      meta_busy_r <= tick.busy;
      meta_tmo_r  <= tick.timed_out;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pd_sck    = pd_r;
  assign out_done_res  = done_res_r;
  assign out_average   = average_r;
  assign out_corrected = corrected_r;
  assign out_units     = units_r;
  assign out_timed_out = tmo_res_r;
  assign out_busy_res  = busy_res_r;

`ifndef ASSERT_OFF
  a_calc_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    calc_r |-> !in_ready)
    else $error("input accepted while measurement arithmetic runs");

  a_done_only_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    arith_done |-> calc_r)
    else $error("arithmetic finished with no measurement pending");

  a_launch_sets_calc: assert property (@(posedge clk) disable iff (!rst_n)
    tick_go && tick.present |=> calc_r && !out_valid_r)
    else $error("finishing tick did not start the arithmetic");

  a_full_slot_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while result slot is held");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res)
    else $error("finished measurement reported as busy");
`endif

endmodule

`default_nettype wire

@@ rtl/core/lcadc_seq.sv @@
// tick sequencer: ready wait, serial bit clocking, gain pulses, reading sum
// depends on lcadc_pkg
`timescale 1ns / 1ps
`default_nettype none

module lcadc_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         tick_go,
  input  logic                         start_req,
  input  logic                         dout,
  input  logic [lcadc_pkg::GAIN_W-1:0] gain_pulses,
  input  logic [lcadc_pkg::CNT_W-1:0]  average_count,
  input  logic [lcadc_pkg::TMO_W-1:0]  timeout_ticks,
  input  logic                         power_down,
  output lcadc_pkg::tick_t             tick_o
);
  import lcadc_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAIT,
    PH_BIT_HI,
    PH_BIT_LO,
    PH_GAIN_HI,
    PH_GAIN_LO
  } phase_t;

  phase_t                  phase_r, phase_nxt;
  logic [BIT_CNT_W-1:0]    bit_cnt_r, bit_cnt_nxt;
  logic [SAMPLE_BITS-1:0]  shift_r, shift_nxt;
  logic [TMO_W-1:0]        wait_r, wait_nxt;
  logic [CNT_W-1:0]        reads_r, reads_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic                    tmo_r, tmo_nxt;

  logic [TMO_W-1:0]        wait_inc;
  logic [CNT_W-1:0]        reads_inc;
  logic signed [SUM_W-1:0] sample;
  logic                    finish;
  logic                    present;
  logic                    pd;

  assign wait_inc  = wait_r + 1'b1;
  assign reads_inc = reads_r + 1'b1;
  assign sample    = {{(SUM_W - SAMPLE_BITS){shift_r[SAMPLE_BITS-1]}}, shift_r};

  always_comb begin
    phase_nxt   = phase_r;
    bit_cnt_nxt = bit_cnt_r;
    shift_nxt   = shift_r;
    wait_nxt    = wait_r;
    reads_nxt   = reads_r;
    sum_nxt     = sum_r;
    tmo_nxt     = tmo_r;
    finish      = 1'b0;
    present     = 1'b0;
    pd          = 1'b0;
    if (power_down) begin
      // clock held high, any measurement dropped
      phase_nxt = PH_IDLE;
      pd        = 1'b1;
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
          if (start_req) begin
            sum_nxt   = '0;
            reads_nxt = '0;
            tmo_nxt   = 1'b0;
            wait_nxt  = '0;
            if (average_count == '0) present = 1'b1;
            else phase_nxt = PH_WAIT;
          end
        end
        PH_WAIT: begin
          if (!dout) begin
            phase_nxt   = PH_BIT_HI;
            bit_cnt_nxt = '0;
            shift_nxt   = '0;
          end else begin
            wait_nxt = wait_inc;
            // a zero timeout ends the wait at once; a wrapped count also ends it
            if (wait_inc >= timeout_ticks || wait_inc == '0) begin
              tmo_nxt     = 1'b1;
              phase_nxt   = PH_BIT_HI;
              bit_cnt_nxt = '0;
              shift_nxt   = '0;
            end
          end
        end
        PH_BIT_HI: begin
          pd          = 1'b1;
          shift_nxt   = {shift_r[SAMPLE_BITS-2:0], dout};
          bit_cnt_nxt = bit_cnt_r + 1'b1;
          phase_nxt   = PH_BIT_LO;
        end
        PH_BIT_LO: begin
          if (bit_cnt_r >= BIT_CNT_W'(SAMPLE_BITS)) begin
            bit_cnt_nxt = '0;
            if (gain_pulses == '0) finish = 1'b1;
            else phase_nxt = PH_GAIN_HI;
          end else begin
            phase_nxt = PH_BIT_HI;
          end
        end
        PH_GAIN_HI: begin
          pd          = 1'b1;
          bit_cnt_nxt = bit_cnt_r + 1'b1;
          phase_nxt   = PH_GAIN_LO;
        end
        PH_GAIN_LO: begin
          if (bit_cnt_r >= BIT_CNT_W'(gain_pulses)) finish = 1'b1;
          else phase_nxt = PH_GAIN_HI;
        end
        default: phase_nxt = PH_IDLE;
      endcase

      if (finish) begin
        sum_nxt     = sum_r + sample;
        reads_nxt   = reads_inc;
        bit_cnt_nxt = '0;
        if (reads_inc >= average_count || reads_inc == '0) begin
          present   = 1'b1;
          phase_nxt = PH_IDLE;
        end else begin
          phase_nxt = PH_WAIT;
          wait_nxt  = '0;
        end
      end
    end
  end

  always_comb begin
    tick_o.pd_sck    = pd;
    tick_o.busy      = (phase_nxt != PH_IDLE);
    tick_o.present   = present;
    tick_o.timed_out = tmo_nxt;
    tick_o.sum       = sum_nxt;
    tick_o.count     = reads_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      bit_cnt_r <= '0;
      shift_r   <= '0;
      wait_r    <= '0;
      reads_r   <= '0;
      sum_r     <= '0;
      tmo_r     <= 1'b0;
    end else if (tick_go) begin
      phase_r   <= phase_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      shift_r   <= shift_nxt;
      wait_r    <= wait_nxt;
      reads_r   <= reads_nxt;
      sum_r     <= sum_nxt;
      tmo_r     <= tmo_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/lcadc_arith.sv @@
// shared iterative arithmetic: restoring divide, offset subtract with
// saturation, and a split Q16.16 multiply; depends on lcadc_pkg
`timescale 1ns / 1ps
`default_nettype none

module lcadc_arith (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [lcadc_pkg::SUM_W-1:0]   sum_i,
  input  logic [lcadc_pkg::CNT_W-1:0]          count_i,
  input  logic signed [lcadc_pkg::COR_W-1:0]   offset_i,
  input  logic signed [lcadc_pkg::SCALE_W-1:0] scale_i,
  output logic                                 done_o,
  output lcadc_pkg::meas_t                     res_o
);
  import lcadc_pkg::*;

  localparam int HALF_W = SCALE_W / 2;
  localparam int PP_W   = COR_W + HALF_W + 1;

  typedef enum logic [2:0] {
    A_IDLE,
    A_DIV,
    A_SIGN,
    A_SUB,
    A_MUL_LO,
    A_MUL_HI
  } astate_t;

  astate_t                  state_r;
  logic [DIV_CNT_W-1:0]     cnt_r;
  logic [SUM_W-1:0]         num_r, num_nxt;
  logic [CNT_W-1:0]         rem_r, rem_nxt;
  logic [CNT_W-1:0]         den_r;
  logic                     neg_r;
  logic signed [SUM_W-1:0]  avg_r;
  logic signed [COR_W-1:0]  cor_r, cor_nxt;
  logic signed [PROD_W-1:0] acc_r;
  logic                     done_r;

  logic [CNT_W:0]           rem_sh;
  logic                     ge;
  logic [SUM_W-1:0]         mag;
  logic signed [COR_W:0]    diff;
  logic signed [HALF_W:0]   mul_op;
  logic signed [PP_W-1:0]   pp;

  assign mag = sum_i[SUM_W-1] ? SUM_W'(-sum_i) : SUM_W'(sum_i);

  // one quotient bit per cycle
  assign rem_sh  = {rem_r, num_r[SUM_W-1]};
  assign ge      = (rem_sh >= {1'b0, den_r});
  assign rem_nxt = ge ? CNT_W'(rem_sh - {1'b0, den_r}) : rem_sh[CNT_W-1:0];
  assign num_nxt = {num_r[SUM_W-2:0], ge};

  assign diff    = (COR_W + 1)'(avg_r) - (COR_W + 1)'(offset_i);
  assign cor_nxt = (diff[COR_W] == diff[COR_W-1]) ? diff[COR_W-1:0]
                 : {diff[COR_W], {(COR_W - 1){~diff[COR_W]}}};

  // low half unsigned, high half signed, through one multiplier
  assign mul_op = (state_r == A_MUL_HI) ? {scale_i[SCALE_W-1], scale_i[SCALE_W-1:HALF_W]}
                                        : {1'b0, scale_i[HALF_W-1:0]};
  assign pp     = PP_W'(cor_r) * PP_W'(mul_op);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        A_IDLE: begin
          if (start) begin
            num_r   <= mag;
            rem_r   <= '0;
            den_r   <= count_i;
            neg_r   <= sum_i[SUM_W-1];
            cnt_r   <= DIV_CNT_W'(SUM_W - 1);
            state_r <= A_DIV;
          end
        end
        A_DIV: begin
          num_r <= num_nxt;
          rem_r <= rem_nxt;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) state_r <= A_SIGN;
        end
        A_SIGN: begin
          if (den_r == '0) avg_r <= '0;
          else if (neg_r) avg_r <= -$signed(num_r);
          else avg_r <= $signed(num_r);
          state_r <= A_SUB;
        end
        A_SUB: begin
          cor_r   <= cor_nxt;
          state_r <= A_MUL_LO;
        end
        A_MUL_LO: begin
          acc_r   <= PROD_W'(pp);
          state_r <= A_MUL_HI;
        end
        A_MUL_HI: begin
          acc_r   <= acc_r + (PROD_W'(pp) <<< HALF_W);
          done_r  <= 1'b1;
          state_r <= A_IDLE;
        end
        default: state_r <= A_IDLE;
      endcase
    end
  end

  assign done_o          = done_r;
  assign res_o.average   = avg_r[AVG_W-1:0];
  assign res_o.corrected = cor_r;
  // the shifted product always fits in the output width
  assign res_o.units     = acc_r[Q_FRAC +: UNITS_W];

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// self-checking bench for load_cell_adc_reader_unit: drives converter ticks and register writes
// predicts every per-tick readout in-bench and compares it field by field; needs lcadc_pkg
`timescale 1ns / 1ps

module testbench;
  import lcadc_pkg::*;

  localparam int ITEMS          = 1600;
  localparam int SETTLE_CYCLES  = 40;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT    = 4000000;

  typedef enum logic [2:0] {
    RD_IDLE, RD_WAIT, RD_BIT_HI, RD_BIT_LO, RD_GAIN_HI, RD_GAIN_LO
  } rd_phase_t;

  typedef struct packed {
    logic                      pd_sck;
    logic                      done;
    logic signed [AVG_W-1:0]   average;
    logic signed [COR_W-1:0]   corrected;
    logic signed [UNITS_W-1:0] units;
    logic                      timed_out;
    logic                      busy;
  } readout_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_start_req = 1'b0;
  logic in_dout = 1'b1;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_pd_sck;
  logic out_done_res;
  logic signed [AVG_W-1:0] out_average;
  logic signed [COR_W-1:0] out_corrected;
  logic signed [UNITS_W-1:0] out_units;
  logic out_timed_out;
  logic out_busy_res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  load_cell_adc_reader_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_start_req(in_start_req), .in_dout(in_dout),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pd_sck(out_pd_sck), .out_done_res(out_done_res),
    .out_average(out_average), .out_corrected(out_corrected),
    .out_units(out_units), .out_timed_out(out_timed_out),
    .out_busy_res(out_busy_res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // predicted register file
  logic [GAIN_W-1:0]         cfg_gain    = 2'd1;
  logic [CNT_W-1:0]          cfg_count   = 8'd1;
  logic signed [COR_W-1:0]   cfg_offset  = '0;
  logic signed [SCALE_W-1:0] cfg_scale   = 32'sd65536;
  logic [TMO_W-1:0]          cfg_timeout = 16'd20000;
  logic                      cfg_pd      = 1'b0;

  // predicted sequencer state
  rd_phase_t               rd_phase = RD_IDLE;
  logic [4:0]              bit_cnt  = '0;
  logic [23:0]             shift_r  = '0;
  logic [TMO_W-1:0]        wait_tmr = '0;
  logic [CNT_W-1:0]        readings = '0;
  logic signed [SUM_W-1:0] sum_acc  = '0;
  logic                    tmo_seen = 1'b0;

  readout_t readouts_due[$];
  int error_count = 0;
  int sent_ticks  = 0;

  // stimulus shaping
  logic [23:0] queued_words[$];
  logic [23:0] cur_word = '0;
  logic [23:0] pin_word = '0;
  bit pin_word_on = 1'b0;
  int not_ready_pct = 30;
  bit tx_pace = 1'b1;
  bit tx_offering = 1'b0;
  bit cfg_offering = 1'b0;
  bit drained = 1'b1;
  logic rx_pace = 1'b1;
  logic rx_hold = 1'b0;
  int rx_gap = 0;
  int cycle_cnt = 0;
  event hold_ev;

  function automatic readout_t measurement_result();
    readout_t r;
    longint total, avg, cor, scaled;
    r = '0;
    total = longint'(sum_acc);
    avg = (readings != 0) ? total / longint'(readings) : 0;
    cor = avg - longint'(cfg_offset);
    if (cor > 64'sd2147483647) cor = 64'sd2147483647;
    if (cor < -64'sd2147483648) cor = -64'sd2147483648;
    scaled = (cor * longint'(cfg_scale)) >>> Q_FRAC;
    if (scaled > 64'sd140737488355327) scaled = 64'sd140737488355327;
    if (scaled < -64'sd140737488355328) scaled = -64'sd140737488355328;
    r.done = 1'b1;
    r.average = avg[AVG_W-1:0];
    r.corrected = cor[COR_W-1:0];
    r.units = scaled[UNITS_W-1:0];
    r.timed_out = tmo_seen;
    return r;
  endfunction

  task automatic advance_readout(input logic start, input logic dout);
    readout_t r;
    bit finish;
    r = '0;
    finish = 1'b0;
    if (cfg_pd) begin
      rd_phase = RD_IDLE;
      r.pd_sck = 1'b1;
    end else begin
      case (rd_phase)
        RD_IDLE: begin
          if (start) begin
            sum_acc = '0;
            readings = '0;
            tmo_seen = 1'b0;
            wait_tmr = '0;
            if (cfg_count == 0) r = measurement_result();
            else rd_phase = RD_WAIT;
          end
        end
        RD_WAIT: begin
          if (!dout) begin
            rd_phase = RD_BIT_HI;
            bit_cnt = '0;
            shift_r = '0;
          end else begin
            wait_tmr = wait_tmr + 1'b1;
            // a wrapped timer counts as expired too
            if (wait_tmr >= cfg_timeout || wait_tmr == 0) begin
              tmo_seen = 1'b1;
              rd_phase = RD_BIT_HI;
              bit_cnt = '0;
              shift_r = '0;
            end
          end
        end
        RD_BIT_HI: begin
          r.pd_sck = 1'b1;
          shift_r = {shift_r[22:0], dout};
          bit_cnt = bit_cnt + 1'b1;
          rd_phase = RD_BIT_LO;
        end
        RD_BIT_LO: begin
          if (bit_cnt >= SAMPLE_BITS) begin
            bit_cnt = '0;
            if (cfg_gain == 0) finish = 1'b1;
            else rd_phase = RD_GAIN_HI;
          end else begin
            rd_phase = RD_BIT_HI;
          end
        end
        RD_GAIN_HI: begin
          r.pd_sck = 1'b1;
          bit_cnt = bit_cnt + 1'b1;
          rd_phase = RD_GAIN_LO;
        end
        RD_GAIN_LO: begin
          if (bit_cnt >= cfg_gain) finish = 1'b1;
          else rd_phase = RD_GAIN_HI;
        end
        default: rd_phase = RD_IDLE;
      endcase
      if (finish) begin
        sum_acc = sum_acc + $signed(shift_r);
        readings = readings + 1'b1;
        bit_cnt = '0;
        if (readings >= cfg_count || readings == 0) begin
          r = measurement_result();
          rd_phase = RD_IDLE;
        end else begin
          rd_phase = RD_WAIT;
          wait_tmr = '0;
        end
      end
    end
    r.busy = (rd_phase != RD_IDLE);
    readouts_due.push_back(r);
  endtask

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_GAIN:    cfg_gain = data[GAIN_W-1:0];
      REG_AVG_CNT: cfg_count = data[CNT_W-1:0];
      REG_OFFSET:  cfg_offset = data;
      REG_SCALE:   cfg_scale = data;
      REG_TIMEOUT: cfg_timeout = data[TMO_W-1:0];
      REG_PDOWN:   cfg_pd = data[0];
      default: ;
    endcase
  endtask

  task automatic release_cfg();
    if (cfg_offering) begin
      cfg_valid <= 1'b0;
      cfg_offering = 1'b0;
    end
  endtask

  // sender pause: all readouts back, then let the arithmetic tail settle
  task automatic wait_idle();
    if (!drained) begin
      if (tx_offering) in_valid <= 1'b0;
      tx_offering = 1'b0;
      while (readouts_due.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
      drained = 1'b1;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    cfg_offering = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
  endtask

  task automatic send_tick(input logic start, input logic dout);
    int gap;
    release_cfg();
    gap = tx_pace ? $urandom_range(0, 17) : 0;
    if (gap != 0) begin
      if (tx_offering) in_valid <= 1'b0;
      tx_offering = 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_start_req <= start;
    in_dout <= dout;
    tx_offering = 1'b1;
    drained = 1'b0;
    do @(posedge clk); while (!in_ready);
    sent_ticks++;
    advance_readout(start, dout);
  endtask

  task automatic next_word();
    if (queued_words.size() != 0) begin
      cur_word = queued_words.pop_front();
    end else if (pin_word_on) begin
      cur_word = pin_word;
    end else begin
      case ($urandom_range(0, 5))
        0: cur_word = 24'h7fffff;
        1: cur_word = 24'h800000;
        2: cur_word = 24'hffffff;
        3: cur_word = 24'h000000;
        default: cur_word = 24'($urandom);
      endcase
    end
  endtask

  // data line level that keeps the serial transfer well formed
  task automatic choose_dout(output logic dout);
    case (rd_phase)
      RD_WAIT: dout = ($urandom_range(1, 100) <= not_ready_pct);
      RD_BIT_HI: begin
        if (bit_cnt == 0) next_word();
        dout = cur_word[23 - bit_cnt];
      end
      default: dout = 1'($urandom_range(0, 1));
    endcase
  endtask

  task automatic run_measurement(input int read_limit, input int tick_limit);
    int n;
    logic dout;
    send_tick(1'b1, 1'($urandom_range(0, 1)));
    n = 1;
    while (rd_phase != RD_IDLE && (read_limit == 0 || readings < read_limit)
           && (tick_limit == 0 || n < tick_limit)) begin
      choose_dout(dout);
      send_tick($urandom_range(0, 15) == 0, dout);
      n++;
    end
  endtask

  task automatic idle_noise(input int n);
    repeat (n) send_tick(1'b0, 1'($urandom_range(0, 1)));
  endtask

  function automatic logic [31:0] wide_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'(int'($urandom_range(0, 200000)) - 100000);
      4: return 32'(int'($urandom_range(0, 131072)));
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------

  task automatic test_reset_values();
    queued_words.push_back(24'h123456);
    run_measurement(0, 0);
    run_measurement(0, 0);
  endtask

  task automatic test_sample_extremes();
    write_reg(REG_TIMEOUT, 12);
    write_reg(REG_GAIN, 3);
    queued_words = '{24'h7fffff, 24'h800000, 24'hffffff, 24'h000000};
    repeat (4) run_measurement(0, 0);
    write_reg(REG_GAIN, 0);
    queued_words = '{24'h555555, 24'haaaaaa};
    repeat (2) run_measurement(0, 0);
    write_reg(REG_GAIN, 2);
    write_reg(REG_AVG_CNT, 2);
    queued_words = '{24'h000001, 24'h000002, 24'hfffffe, 24'hffffff};
    repeat (2) run_measurement(0, 0);
    write_reg(REG_AVG_CNT, 1);
  endtask

  task automatic test_wait_timeout();
    // zero timeout behaves as a single tick
    write_reg(REG_TIMEOUT, 0);
    not_ready_pct = 100;
    run_measurement(0, 0);
    write_reg(REG_TIMEOUT, 1);
    run_measurement(0, 0);
    write_reg(REG_TIMEOUT, 32'h0000_ffff);
    not_ready_pct = 50;
    run_measurement(0, 0);
    write_reg(REG_TIMEOUT, 6);
    not_ready_pct = 30;
  endtask

  task automatic test_offset_scale();
    write_reg(REG_OFFSET, 32'h7fff_ffff);
    write_reg(REG_SCALE, 32'h7fff_ffff);
    queued_words.push_back(24'h800000);
    run_measurement(0, 0);
    write_reg(REG_OFFSET, 32'h8000_0000);
    queued_words.push_back(24'h7fffff);
    run_measurement(0, 0);
    write_reg(REG_SCALE, 32'h8000_0000);
    queued_words.push_back(24'hffffff);
    run_measurement(0, 0);
    write_reg(REG_SCALE, 0);
    write_reg(REG_OFFSET, 32'd1000);
    run_measurement(0, 0);
    write_reg(REG_OFFSET, 0);
    write_reg(REG_SCALE, 32'd65536);
  endtask

  task automatic test_zero_count();
    write_reg(REG_OFFSET, 32'hffff_fc18);
    write_reg(REG_SCALE, 32'hfffe_8000);
    write_reg(REG_AVG_CNT, 0);
    run_measurement(0, 0);
    run_measurement(0, 0);
    write_reg(REG_AVG_CNT, 1);
  endtask

  task automatic test_count_change();
    // count drops mid-measurement: ends early, averages over what was summed
    write_reg(REG_AVG_CNT, 3);
    run_measurement(1, 0);
    write_reg(REG_AVG_CNT, 1);
    run_measurement(0, 0);
  endtask

  task automatic test_power_down();
    write_reg(REG_AVG_CNT, 2);
    run_measurement(0, 30);
    write_reg(REG_PDOWN, 1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    write_reg(REG_PDOWN, 0);
    run_measurement(0, 0);
  endtask

  task automatic test_back_pressure();
    tx_pace = 1'b0;
    rx_pace <= 1'b0;
    write_reg(REG_AVG_CNT, 2);
    // receiver holds off while the sender keeps offering ticks
    -> hold_ev;
    run_measurement(0, 0);
    wait_idle();
    tx_pace = 1'b1;
    rx_pace <= 1'b1;
  endtask

  task automatic test_long_average();
    write_reg(REG_AVG_CNT, 3);
    write_reg(REG_GAIN, 0);
    write_reg(REG_OFFSET, 32'h7fff_ffff);
    write_reg(REG_SCALE, 32'h7fff_ffff);
    pin_word = 24'h800000;
    pin_word_on = 1'b1;
    not_ready_pct = 0;
    tx_pace = 1'b0;
    rx_pace <= 1'b0;
    run_measurement(0, 0);
    pin_word_on = 1'b0;
    tx_pace = 1'b1;
    rx_pace <= 1'b1;
  endtask

  task automatic test_random_measurements();
    do begin
      if ($urandom_range(0, 1)) write_reg(REG_GAIN, $urandom_range(0, 3));
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 19))
          0: write_reg(REG_AVG_CNT, 0);
          1, 2, 3: write_reg(REG_AVG_CNT, $urandom_range(4, 8));
          4: write_reg(REG_AVG_CNT, $urandom_range(9, 16));
          default: write_reg(REG_AVG_CNT, $urandom_range(1, 3));
        endcase
      end
      if ($urandom_range(0, 1)) write_reg(REG_OFFSET, wide_value());
      if ($urandom_range(0, 1)) write_reg(REG_SCALE, wide_value());
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 7))
          0: write_reg(REG_TIMEOUT, 0);
          1: write_reg(REG_TIMEOUT, 1);
          2: write_reg(REG_TIMEOUT, 32'h0000_ffff);
          3: write_reg(REG_TIMEOUT, 20000);
          default: write_reg(REG_TIMEOUT, $urandom_range(2, 40));
        endcase
      end
      // a stuck-high data line would wait out a long timeout
      not_ready_pct = (cfg_timeout > 40) ? $urandom_range(0, 90) : $urandom_range(0, 100);
      tx_pace = ($urandom_range(0, 3) != 0);
      rx_pace <= ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 3) == 0) idle_noise($urandom_range(1, 4));
        run_measurement(0, 0);
      end
      if ($urandom_range(0, 7) == 0) begin
        run_measurement(0, $urandom_range(2, 60));
        write_reg(REG_PDOWN, 1);
        repeat ($urandom_range(1, 5)) begin
          send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        write_reg(REG_PDOWN, 0);
      end
    end while (sent_ticks < ITEMS);
  endtask

  // ---------------------------------------------------------------------------

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_sample_extremes();
    test_wait_timeout();
    test_offset_scale();
    test_zero_count();
    test_count_change();
    test_power_down();
    test_back_pressure();
    test_long_average();
    test_random_measurements();
    wait_idle();
    release_cfg();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && readouts_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // receiver: random stalls per transaction, plus a long hold on request
  always @(posedge clk) begin : readout_check
    readout_t due;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (readouts_due.size() == 0) begin
          $error("readout transaction with nothing expected");
          error_count++;
        end else begin
          due = readouts_due.pop_front();
          if (out_pd_sck !== due.pd_sck) begin
            $error("pd_sck: expected %0d, actual %0d", due.pd_sck, out_pd_sck);
            error_count++;
          end
          if (out_done_res !== due.done) begin
            $error("done_res: expected %0d, actual %0d", due.done, out_done_res);
            error_count++;
          end
          if (out_average !== due.average) begin
            $error("average: expected %0d, actual %0d", due.average, out_average);
            error_count++;
          end
          if (out_corrected !== due.corrected) begin
            $error("corrected: expected %0d, actual %0d", due.corrected, out_corrected);
            error_count++;
          end
          if (out_units !== due.units) begin
            $error("units: expected %0d, actual %0d", due.units, out_units);
            error_count++;
          end
          if (out_timed_out !== due.timed_out) begin
            $error("timed_out: expected %0d, actual %0d", due.timed_out, out_timed_out);
            error_count++;
          end
          if (out_busy_res !== due.busy) begin
            $error("busy_res: expected %0d, actual %0d", due.busy, out_busy_res);
            error_count++;
          end
        end
        rx_gap = rx_pace ? $urandom_range(0, 17) : 0;
      end else if (rx_gap > 0) begin
        rx_gap--;
      end
      out_ready <= (rx_gap == 0) && !rx_hold;
    end
  end

  always begin
    @(hold_ev);
    rx_hold <= 1'b1;
    repeat (RX_HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule
